FILE: src/pll_rotor_angle_tracker_unit_assert.svh
// Assertion macros for the checker file of the rotor angle tracker.
`ifndef PLL_ROTOR_ANGLE_TRACKER_UNIT_ASSERT_SVH
`define PLL_ROTOR_ANGLE_TRACKER_UNIT_ASSERT_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define PRA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pll rotor angle tracker assertion failed");

// Non-overlapping implication: the consequent must hold in the next cycle.
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pll rotor angle tracker assertion failed");

`endif

FILE: src/pra_pkg.sv
`timescale 1ns / 1ps

package pra_pkg;

    localparam int SINCOS_TABLE_BITS = 10;
    localparam int POSITION_BITS     = 14;

    localparam int ANG_W        = 16;
    localparam int EST_W        = 24;
    localparam int POS_W        = 14;
    localparam int ADC_W        = 12;
    localparam int SPEED_W      = 32;
    localparam int ERR_W        = 16;
    localparam int GAIN_W       = 24;
    localparam int LIMIT_W      = 31;
    localparam int PP_W         = 4;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 18;
    localparam int ZW           = 18;
    localparam int CORDIC_X0    = 19898;

    localparam int MUL_A_W      = 26;
    localparam int MUL_B_W      = 18;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int FRAC_SHIFT   = 15;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 31;

    localparam logic [ANG_W-1:0] SC_MASK =
        ANG_W'({ANG_W{1'b1}} << (ANG_W - SINCOS_TABLE_BITS));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_MODE  = 3'd0,
        CFG_POLE_PAIRS   = 3'd1,
        CFG_PROP_GAIN    = 3'd2,
        CFG_INTEG_GAIN   = 3'd3,
        CFG_SPEED_LIMIT  = 3'd4,
        CFG_ANGLE_OFFSET = 3'd5,
        CFG_ADC_ZERO     = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAS_GO,
        ST_MEAS_WAIT,
        ST_EST_GO,
        ST_EST_WAIT,
        ST_MUL_AC,
        ST_MUL_BS,
        ST_ERR,
        ST_MUL_KI,
        ST_MUL_KP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [ADC_W-1:0] sense_a;
        logic [ADC_W-1:0] sense_b;
    } t_in_beat;

    typedef struct packed {
        logic [ANG_W-1:0]          rotor_angle;
        logic signed [SPEED_W-1:0] rotor_speed;
        logic                      speed_clamped;
    } t_out_beat;

    typedef struct packed {
        logic             start;
        logic [ANG_W-1:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] sin_val;
        logic signed [CW-1:0] cos_val;
    } t_cordic_rsp;

    function automatic logic signed [ZW-1:0] atan_step(input logic [ITER_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            4'd14:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/pra_cordic.sv
`timescale 1ns / 1ps

module pra_cordic
    import pra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    localparam logic signed [ZW-1:0] QUARTER = ZW'(16384);
    localparam logic signed [ZW-1:0] HALF    = ZW'(32768);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_flip;
    logic [ITER_W-1:0]     r_iter;
    logic signed [CW-1:0]  r_x;
    logic signed [CW-1:0]  r_y;
    logic signed [ZW-1:0]  r_z;

    logic [ANG_W-1:0]      ang_m;
    logic signed [ZW-1:0]  z_raw;
    logic signed [ZW-1:0]  z_fold;
    logic                  flip;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [ZW-1:0]  at;
    logic signed [CW-1:0]  n_x;
    logic signed [CW-1:0]  n_y;
    logic signed [ZW-1:0]  n_z;
    logic                  last;

    always_comb begin
        ang_m = i_req.angle & SC_MASK;
        z_raw = {{(ZW - ANG_W){ang_m[ANG_W-1]}}, ang_m};
        flip  = 1'b0;
        if (z_raw > QUARTER) begin
            z_fold = z_raw - HALF;
            flip   = 1'b1;
        end else if (z_raw < -QUARTER) begin
            z_fold = z_raw + HALF;
            flip   = 1'b1;
        end else begin
            z_fold = z_raw;
        end
    end

    always_comb begin
        dx   = r_y >>> r_iter;
        dy   = r_x >>> r_iter;
        at   = atan_step(r_iter);
        last = (r_iter == ITER_W'(CORDIC_STEPS - 1));
        if (!r_z[ZW-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - at;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + at;
        end
        if (last && r_flip) begin
            n_x = -n_x;
            n_y = -n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= CW'(CORDIC_X0);
            r_y    <= '0;
            r_z    <= z_fold;
            r_flip <= flip;
            r_iter <= '0;
        end else if (r_busy) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_iter <= r_iter + ITER_W'(1);
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.sin_val = r_y;
    assign o_rsp.cos_val = r_x;

endmodule

FILE: src/pll_rotor_angle_tracker_unit.sv
`timescale 1ns / 1ps

// Rotor angle tracker: one sensor sample in, one angle and speed beat out.
// The input channel carries position and two hall ADC samples; only the fields
// of the selected sensor mode are used. The block raises o_in_stall from the
// cycle after a beat is accepted until its result has been written to the
// output register.
// Each beat runs through the shared 16-iteration CORDIC, once for the measured
// angle in absolute mode only and once for the estimate, then through the shared
// multiplier for the phase detector and the PI update. A new beat is accepted
// only after the previous result has been written to the output register.
// The next beat is accepted while a finished result still waits at the output.
// If the receiver stalls, the result holds; a following result waits in the
// update step until the output register is free.
// Configuration writes are always ready and must only be issued while idle.
// Synchronous reset loads the register defaults and zeroes the angle, speed
// and error state; no output beat is pending after reset.
module pll_rotor_angle_tracker_unit
    import pra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                     r_state;
    t_state                     n_state;

    logic                       r_sensor_mode;
    logic [PP_W-1:0]            r_pole_pairs;
    logic [GAIN_W-1:0]          r_prop_gain;
    logic [GAIN_W-1:0]          r_integ_gain;
    logic [LIMIT_W-1:0]         r_speed_limit;
    logic [ANG_W-1:0]           r_angle_offset;
    logic [ADC_W-1:0]           r_adc_zero;

    logic [EST_W-1:0]           r_angle;
    logic signed [SPEED_W-1:0]  r_speed;
    logic signed [ERR_W-1:0]    r_prev;

    logic [POS_W-1:0]           r_pos;
    logic signed [CW-1:0]       r_alpha;
    logic signed [CW-1:0]       r_beta;
    logic signed [CW-1:0]       r_se;
    logic signed [CW-1:0]       r_ce;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;
    logic signed [ERR_W-1:0]    r_err;

    logic                       r_out_valid;
    t_out_beat                  r_out;

    t_cordic_req                cordic_req;
    t_cordic_rsp                cordic_rsp;

    logic                       in_acc;
    logic                       out_free;
    logic                       ld_meas;
    logic                       ld_est;
    logic                       ld_prod;
    logic                       ld_acc;
    logic                       ld_err;
    logic                       commit;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;

    logic [POS_W+PP_W-1:0]      pos_prod;
    logic [ANG_W-1:0]           el_angle;
    logic signed [ADC_W:0]      diff_a;
    logic signed [ADC_W:0]      diff_b;
    logic signed [PROD_W-1:0]   diff;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [ERR_W-1:0]    err_sat;
    logic signed [SPEED_W+1:0]  sp;
    logic signed [SPEED_W+1:0]  lim;
    logic signed [SPEED_W-1:0]  speed_new;
    logic                       clamped;
    logic [EST_W-1:0]           angle_new;

    pra_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        pos_prod = r_pos * r_pole_pairs;
        el_angle = ANG_W'(ANG_W'(pos_prod[POSITION_BITS-1:0]) << (ANG_W - POSITION_BITS));
        diff_a   = signed'({1'b0, i_in_data.sense_a}) - signed'({1'b0, r_adc_zero});
        diff_b   = signed'({1'b0, i_in_data.sense_b}) - signed'({1'b0, r_adc_zero});
    end

    always_comb begin
        diff    = r_acc - r_prod;
        shifted = diff >>> FRAC_SHIFT;
        if (shifted > PROD_W'(32767)) begin
            err_sat = 16'sh7FFF;
        end else if (shifted < -PROD_W'(32768)) begin
            err_sat = -16'sh8000;
        end else begin
            err_sat = shifted[ERR_W-1:0];
        end
        sp  = {{2{r_speed[SPEED_W-1]}}, r_speed} + shifted[SPEED_W+1:0];
        lim = {3'b000, r_speed_limit};
        clamped = 1'b0;
        if (sp > lim) begin
            speed_new = lim[SPEED_W-1:0];
            clamped   = 1'b1;
        end else if (sp < -lim) begin
            speed_new = SPEED_W'(-lim);
            clamped   = 1'b1;
        end else begin
            speed_new = sp[SPEED_W-1:0];
        end
        angle_new = r_angle + speed_new[EST_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = r_sensor_mode ? ST_EST_GO : ST_MEAS_GO;
                end
            end
            ST_MEAS_GO:   n_state = ST_MEAS_WAIT;
            ST_MEAS_WAIT: begin
                if (cordic_rsp.done) begin
                    n_state = ST_EST_GO;
                end
            end
            ST_EST_GO:    n_state = ST_EST_WAIT;
            ST_EST_WAIT: begin
                if (cordic_rsp.done) begin
                    n_state = ST_MUL_AC;
                end
            end
            ST_MUL_AC:    n_state = ST_MUL_BS;
            ST_MUL_BS:    n_state = ST_ERR;
            ST_ERR:       n_state = ST_MUL_KI;
            ST_MUL_KI:    n_state = ST_MUL_KP;
            ST_MUL_KP:    n_state = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = 1'b1;
        cordic_req.start = 1'b0;
        cordic_req.angle = r_angle[EST_W-1 -: ANG_W];
        ld_meas          = 1'b0;
        ld_est           = 1'b0;
        ld_prod          = 1'b0;
        ld_acc           = 1'b0;
        ld_err           = 1'b0;
        commit           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        case (r_state)
            ST_IDLE:      o_in_stall = 1'b0;
            ST_MEAS_GO: begin
                cordic_req.start = 1'b1;
                cordic_req.angle = el_angle;
            end
            ST_MEAS_WAIT: ld_meas = cordic_rsp.done;
            ST_EST_GO:    cordic_req.start = 1'b1;
            ST_EST_WAIT:  ld_est = cordic_rsp.done;
            ST_MUL_AC: begin
                ld_prod = 1'b1;
                mul_a   = {{(MUL_A_W - CW){r_alpha[CW-1]}}, r_alpha};
                mul_b   = r_ce;
            end
            ST_MUL_BS: begin
                ld_prod = 1'b1;
                ld_acc  = 1'b1;
                mul_a   = {{(MUL_A_W - CW){r_beta[CW-1]}}, r_beta};
                mul_b   = r_se;
            end
            ST_ERR:       ld_err = 1'b1;
            ST_MUL_KI: begin
                ld_prod = 1'b1;
                mul_a   = {1'b0, {1'b0, r_prop_gain} + {1'b0, r_integ_gain}};
                mul_b   = {{(MUL_B_W - ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            ST_MUL_KP: begin
                ld_prod = 1'b1;
                ld_acc  = 1'b1;
                mul_a   = {2'b00, r_prop_gain};
                mul_b   = {{(MUL_B_W - ERR_W){r_prev[ERR_W-1]}}, r_prev};
            end
            ST_UPD:       commit = out_free;
            default:      o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sensor_mode  <= 1'b0;
            r_pole_pairs   <= 4'd7;
            r_prop_gain    <= 24'd5340353;
            r_integ_gain   <= 24'd267;
            r_speed_limit  <= 31'd26702873;
            r_angle_offset <= 16'd28217;
            r_adc_zero     <= 12'd1241;
            r_angle        <= '0;
            r_speed        <= '0;
            r_prev         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SENSOR_MODE:  r_sensor_mode  <= i_cfg_data[0];
                    CFG_POLE_PAIRS:   r_pole_pairs   <= i_cfg_data[PP_W-1:0];
                    CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_SPEED_LIMIT:  r_speed_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_ANGLE_OFFSET: r_angle_offset <= i_cfg_data[ANG_W-1:0];
                    CFG_ADC_ZERO:     r_adc_zero     <= i_cfg_data[ADC_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (commit) begin
                r_speed     <= speed_new;
                r_prev      <= r_err;
                r_angle     <= angle_new;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos   <= i_in_data.position;
            r_alpha <= {{(CW - ADC_W - 4){diff_a[ADC_W]}}, diff_a, 3'b000};
            r_beta  <= {{(CW - ADC_W - 4){diff_b[ADC_W]}}, diff_b, 3'b000};
        end
        if (ld_meas) begin
            r_alpha <= cordic_rsp.sin_val;
            r_beta  <= cordic_rsp.cos_val;
        end
        if (ld_est) begin
            r_se <= cordic_rsp.sin_val;
            r_ce <= cordic_rsp.cos_val;
        end
        if (ld_prod) begin
            r_prod <= mul_a * mul_b;
        end
        if (ld_acc) begin
            r_acc <= r_prod;
        end
        if (ld_err) begin
            r_err <= err_sat;
        end
        if (commit) begin
            r_out.rotor_angle   <= angle_new[EST_W-1 -: ANG_W] + r_angle_offset;
            r_out.rotor_speed   <= speed_new;
            r_out.speed_clamped <= clamped;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/pra_checker.sv
`timescale 1ns / 1ps

`include "pll_rotor_angle_tracker_unit_assert.svh"

module pra_checker
    import pra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready
);

    logic in_beat;
    logic in_wait;
    logic out_wait;
    logic cfg_beat;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign in_wait  = i_in_valid && o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;
    assign cfg_beat = i_cfg_valid && o_cfg_ready;

    // A stalled result beat stays valid and unchanged.
    `PRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_data))

    // A stalled input beat keeps its payload.
    `PRA_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, $stable(i_in_data))

    // Only one sample is in work at a time.
    `PRA_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_beat, o_in_stall)

    // A new result is written only from the update step, while input is held off.
    `PRA_ASSERT_SAME(a_out_from_update, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // Registers are to be written by the user only while no sample is in work; the block does not enforce it.
    `PRA_ASSERT_SAME(a_cfg_when_idle, i_clk, i_rst_n, cfg_beat, !o_in_stall)

endmodule

bind pll_rotor_angle_tracker_unit pra_checker u_pra_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pra_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_PCT     = 24;
    localparam int PHASES       = 10;
    localparam int PHASE_BEATS  = 114;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int RUN_LIMIT_NS = 20_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    localparam logic [CFG_DATA_W-1:0] DEF_POLES  = 31'd7;
    localparam logic [CFG_DATA_W-1:0] DEF_PROP   = 31'd5340353;
    localparam logic [CFG_DATA_W-1:0] DEF_INTEG  = 31'd267;
    localparam logic [CFG_DATA_W-1:0] DEF_LIMIT  = 31'd26702873;
    localparam logic [CFG_DATA_W-1:0] DEF_OFFSET = 31'd28217;
    localparam logic [CFG_DATA_W-1:0] DEF_ZERO   = 31'd1241;
    localparam logic [CFG_DATA_W-1:0] MAX_GAIN   = 31'hFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] MAX_LIMIT  = 31'h7FFF_FFFF;

    localparam int ATAN_TBL [CORDIC_STEPS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef enum bit {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        t_in_beat               beat;
        bit                     zero_speed;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  mode_r = 1'b0;
    logic [PP_W-1:0]       poles_r = 4'd7;
    logic [GAIN_W-1:0]     kp_r = 24'd5340353;
    logic [GAIN_W-1:0]     ki_r = 24'd267;
    logic [LIMIT_W-1:0]    lim_r = 31'd26702873;
    logic [ANG_W-1:0]      ofs_r = 16'd28217;
    logic [ADC_W-1:0]      zero_r = 12'd1241;

    logic [EST_W-1:0]      est_angle = '0;
    int                    est_speed = 0;
    int                    last_err = 0;

    t_out_beat             rotor_q [$];
    t_row                  plan [$];
    int                    mismatches = 0;
    bit                    steady = 1'b0;
    int                    hold_ask = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;

    pll_rotor_angle_tracker_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    initial begin
        #RUN_LIMIT_NS;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SENSOR_MODE:  mode_r = val[0];
            CFG_POLE_PAIRS:   poles_r = val[PP_W-1:0];
            CFG_PROP_GAIN:    kp_r = val[GAIN_W-1:0];
            CFG_INTEG_GAIN:   ki_r = val[GAIN_W-1:0];
            CFG_SPEED_LIMIT:  lim_r = val[LIMIT_W-1:0];
            CFG_ANGLE_OFFSET: ofs_r = val[ANG_W-1:0];
            CFG_ADC_ZERO:     zero_r = val[ADC_W-1:0];
            default: ;
        endcase
    endfunction

    // Sine and cosine of a turn fraction by the folded 16-step rotation.
    function automatic void rotate(input logic [ANG_W-1:0] turn, output int s, output int c);
        logic [ANG_W-1:0] a;
        int z, x, y, dx, dy;
        bit flip;
        a = turn & SC_MASK;
        z = int'(a);
        if (a[ANG_W-1]) z -= 65536;
        x = CORDIC_X0;
        y = 0;
        flip = 1'b0;
        if (z > 16384) begin
            z -= 32768;
            flip = 1'b1;
        end else if (z < -16384) begin
            z += 32768;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_TBL[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic t_out_beat pll_track(t_in_beat b);
        int alpha, beta, se, ce, err;
        longint raw, delta, sp, lim;
        logic [POS_W-1:0] el;
        t_out_beat o;
        if (mode_r == 1'b0) begin
            el = POS_W'(b.position * poles_r);
            rotate({el, 2'b00}, alpha, beta);
        end else begin
            alpha = (int'(b.sense_a) - int'(zero_r)) * 8;
            beta = (int'(b.sense_b) - int'(zero_r)) * 8;
        end
        rotate(est_angle[EST_W-1:8], se, ce);
        raw = (longint'(alpha) * ce - longint'(beta) * se) >>> FRAC_SHIFT;
        if (raw > 32767) raw = 32767;
        else if (raw < -32768) raw = -32768;
        err = int'(raw);
        delta = ((longint'(kp_r) + longint'(ki_r)) * err - longint'(kp_r) * last_err)
                >>> FRAC_SHIFT;
        sp = longint'(est_speed) + delta;
        lim = longint'(lim_r);
        o.speed_clamped = 1'b0;
        if (sp > lim) begin
            sp = lim;
            o.speed_clamped = 1'b1;
        end else if (sp < -lim) begin
            sp = -lim;
            o.speed_clamped = 1'b1;
        end
        est_speed = int'(sp);
        last_err = err;
        est_angle = est_angle + EST_W'(est_speed);
        o.rotor_angle = est_angle[EST_W-1:8] + ofs_r;
        o.rotor_speed = est_speed;
        return o;
    endfunction

    function automatic logic [ADC_W-1:0] hall_code(int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'hFFF;
        return ADC_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick(logic [CFG_DATA_W-1:0] lo,
                                                   logic [CFG_DATA_W-1:0] hi,
                                                   logic [CFG_DATA_W-1:0] dflt);
        logic [31:0] span;
        span = {1'b0, hi} - {1'b0, lo} + 32'd1;
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return dflt;
            default: return lo + CFG_DATA_W'($urandom % span);
        endcase
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row r;
        r.kind = ROW_REG;
        r.idx = idx;
        r.val = val;
        r.beat = '0;
        r.zero_speed = 1'b0;
        return r;
    endfunction

    function automatic t_row item_row(int p, int a, int b, bit zero_speed);
        t_row r;
        r.kind = ROW_ITEM;
        r.idx = '0;
        r.val = '0;
        r.beat.position = POS_W'(p);
        r.beat.sense_a = ADC_W'(a);
        r.beat.sense_b = ADC_W'(b);
        r.zero_speed = zero_speed;
        return r;
    endfunction

    task automatic check_beat(t_out_beat got);
        t_out_beat want;
        if (rotor_q.size() == 0) begin
            $display("%0t: rotor beat with none pending: angle %0d speed %0d clamp %0b",
                     $time, got.rotor_angle, got.rotor_speed, got.speed_clamped);
            mismatches++;
            return;
        end
        want = rotor_q.pop_front();
        if (got.rotor_angle !== want.rotor_angle) begin
            $display("%0t: rotor_angle expected %0d actual %0d",
                     $time, want.rotor_angle, got.rotor_angle);
            mismatches++;
        end
        if (got.rotor_speed !== want.rotor_speed) begin
            $display("%0t: rotor_speed expected %0d actual %0d",
                     $time, want.rotor_speed, got.rotor_speed);
            mismatches++;
        end
        if (got.speed_clamped !== want.speed_clamped) begin
            $display("%0t: speed_clamped expected %0b actual %0b",
                     $time, want.speed_clamped, got.speed_clamped);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (out_valid && !out_stall) check_beat(out_data);
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // A zero speed limit pins the speed, so that value is known without the tracker.
    task automatic offer(input t_in_beat b, input bit zero_speed);
        t_out_beat pred;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (in_stall);
        pred = pll_track(b);
        if (zero_speed) pred.rotor_speed = '0;
        rotor_q.push_back(pred);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (rotor_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        store_reg(idx, val);
    endtask

    initial begin
        t_in_beat b;
        int step, s, c;
        logic [POS_W-1:0] shaft;
        logic [ANG_W-1:0] hall_turn;

        plan.push_back(item_row(0, 0, 0, 1'b0));
        plan.push_back(item_row(16383, 4095, 4095, 1'b0));
        plan.push_back(item_row('h2000, 'h800, 'h7FF, 1'b0));
        plan.push_back(reg_row(CFG_SPEED_LIMIT, '0));
        plan.push_back(reg_row(CFG_PROP_GAIN, MAX_GAIN));
        plan.push_back(reg_row(CFG_INTEG_GAIN, MAX_GAIN));
        plan.push_back(reg_row(CFG_ANGLE_OFFSET, 31'hFFFF));
        plan.push_back(item_row('h1000, 4095, 0, 1'b1));
        plan.push_back(item_row('h3000, 0, 4095, 1'b1));
        plan.push_back(reg_row(CFG_PROP_GAIN, '0));
        plan.push_back(reg_row(CFG_INTEG_GAIN, '0));
        plan.push_back(item_row(0, 0, 0, 1'b1));
        plan.push_back(item_row(16383, 4095, 4095, 1'b1));
        plan.push_back(reg_row(CFG_SPEED_LIMIT, MAX_LIMIT));
        plan.push_back(reg_row(CFG_ANGLE_OFFSET, '0));
        plan.push_back(reg_row(CFG_POLE_PAIRS, '0));
        plan.push_back(item_row(16383, 0, 4095, 1'b0));
        plan.push_back(item_row('h1555, 4095, 0, 1'b0));
        plan.push_back(reg_row(CFG_POLE_PAIRS, 31'd15));
        plan.push_back(reg_row(CFG_SPARE_IDX, 31'h5555_5555));
        plan.push_back(reg_row(CFG_PROP_GAIN, 31'h10_0000));
        plan.push_back(reg_row(CFG_INTEG_GAIN, 31'h400));
        plan.push_back(item_row(16383, 0, 0, 1'b0));
        plan.push_back(item_row(0, 4095, 4095, 1'b0));
        plan.push_back(item_row('h2AAA, 'hAAA, 'h555, 1'b0));
        plan.push_back(reg_row(CFG_SENSOR_MODE, 31'd1));
        plan.push_back(reg_row(CFG_ADC_ZERO, '0));
        plan.push_back(reg_row(CFG_SPEED_LIMIT, 31'd1000));
        plan.push_back(item_row(16383, 4095, 4095, 1'b0));
        plan.push_back(item_row(0, 0, 4095, 1'b0));
        plan.push_back(item_row(0, 4095, 0, 1'b0));
        plan.push_back(reg_row(CFG_ADC_ZERO, 31'hFFF));
        plan.push_back(item_row(0, 0, 0, 1'b0));
        plan.push_back(item_row(0, 4095, 0, 1'b0));
        plan.push_back(reg_row(CFG_ADC_ZERO, 31'h7FFF_F800));
        plan.push_back(item_row(0, 4095, 0, 1'b0));
        plan.push_back(item_row(16383, 0, 4095, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < plan.size(); r++) begin
            if (plan[r].kind == ROW_REG) begin
                if (r == 0 || plan[r-1].kind != ROW_REG) settle();
                write_reg(plan[r].idx, plan[r].val);
                if (r + 1 == plan.size() || plan[r+1].kind != ROW_REG) cfg_valid <= 1'b0;
            end else begin
                offer(plan[r].beat, plan[r].zero_speed);
            end
        end

        shaft = '0;
        hall_turn = '0;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_SENSOR_MODE, (p < 2) ? CFG_DATA_W'(p) : pick('0, 31'd1, '0));
            write_reg(CFG_POLE_PAIRS, (p < 2) ? DEF_POLES : pick('0, 31'd15, DEF_POLES));
            write_reg(CFG_PROP_GAIN, (p < 2) ? DEF_PROP : pick('0, MAX_GAIN, DEF_PROP));
            write_reg(CFG_INTEG_GAIN, (p < 2) ? DEF_INTEG : pick('0, MAX_GAIN, DEF_INTEG));
            write_reg(CFG_SPEED_LIMIT, (p < 2) ? DEF_LIMIT : pick('0, MAX_LIMIT, DEF_LIMIT));
            write_reg(CFG_ANGLE_OFFSET, (p < 2) ? DEF_OFFSET : pick('0, 31'hFFFF, DEF_OFFSET));
            write_reg(CFG_ADC_ZERO, (p < 2) ? DEF_ZERO : pick('0, 31'hFFF, DEF_ZERO));
            if ($urandom_range(2) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            steady = (p == 4);
            step = int'($urandom_range(80)) - 40;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if ((p == 2 || p == 7) && k == 30) hold_ask <= hold_ask + 1;
                shaft = shaft + POS_W'(step);
                hall_turn = hall_turn + ANG_W'(step * 96);
                if ($urandom_range(99) < 75) begin
                    rotate(hall_turn, s, c);
                    b.position = shaft;
                    b.sense_a = hall_code(int'(zero_r) + (s >>> 3)
                                          + int'($urandom_range(16)) - 8);
                    b.sense_b = hall_code(int'(zero_r) + (c >>> 3)
                                          + int'($urandom_range(16)) - 8);
                end else begin
                    b.position = POS_W'($urandom);
                    b.sense_a = ADC_W'($urandom);
                    b.sense_b = ADC_W'($urandom);
                end
                offer(b, 1'b0);
            end
        end
        settle();
        steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
